// ===== rtl/segment_intersection_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the segment intersection core
// ---------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_CORE_DEFINES_SVH
`define SEGMENT_INTERSECTION_CORE_DEFINES_SVH

// Same-cycle implication, masked during reset
`define SIC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset
`define SIC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sic_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sic_pkg
// Shared constants and types of the segment intersection core.
// ---------------------------------------------------------------------------
package sic_pkg;

    localparam int COORD_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int HIT_BITS          = 24;
    localparam int INT_LIMIT_BITS    = 17;
    localparam int TOL_BITS          = 16;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1;

    // Result status codes
    localparam logic [1:0] ST_FOUND  = 2'd0;
    localparam logic [1:0] ST_FIRST  = 2'd1;
    localparam logic [1:0] ST_SECOND = 2'd2;

    // Per-item flags carried down the divider chain
    typedef struct packed {
        logic den_zero;
        logic neg_a;
        logic neg_b;
        logic ovf_a;
        logic ovf_b;
    } t_flags;

endpackage
`default_nettype wire

// ===== rtl/sic_div_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sic_div_cell
// One restoring-division cell: settles one quotient bit of alpha and beta.
// ---------------------------------------------------------------------------
module sic_div_cell
    import sic_pkg::*;
#(
    parameter int DEN_BITS  = 35,
    parameter int REM_BITS  = 68,
    parameter int QUO_BITS  = 33,
    parameter int BIT_IDX   = 0,
    parameter int SIDE_BITS = 66
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_en,
    input  wire                  i_valid,
    input  t_flags               i_flags,
    input  wire [SIDE_BITS-1:0]  i_side,
    input  wire [DEN_BITS-1:0]   i_den,
    input  wire [REM_BITS-1:0]   i_rem_a,
    input  wire [REM_BITS-1:0]   i_rem_b,
    input  wire [QUO_BITS-1:0]   i_quo_a,
    input  wire [QUO_BITS-1:0]   i_quo_b,
    output logic                 o_valid,
    output t_flags               o_flags,
    output logic [SIDE_BITS-1:0] o_side,
    output logic [DEN_BITS-1:0]  o_den,
    output logic [REM_BITS-1:0]  o_rem_a,
    output logic [REM_BITS-1:0]  o_rem_b,
    output logic [QUO_BITS-1:0]  o_quo_a,
    output logic [QUO_BITS-1:0]  o_quo_b
);

    logic [REM_BITS-1:0] w_div;
    logic                w_geq_a;
    logic                w_geq_b;
    logic [REM_BITS-1:0] n_rem_a;
    logic [REM_BITS-1:0] n_rem_b;
    logic [QUO_BITS-1:0] n_quo_a;
    logic [QUO_BITS-1:0] n_quo_b;

    // Trial subtract of the shifted denominator
    always_comb begin
        w_div   = REM_BITS'(i_den) << BIT_IDX;
        w_geq_a = (i_rem_a >= w_div);
        w_geq_b = (i_rem_b >= w_div);
        n_rem_a = w_geq_a ? (i_rem_a - w_div) : i_rem_a;
        n_rem_b = w_geq_b ? (i_rem_b - w_div) : i_rem_b;
        n_quo_a = i_quo_a;
        n_quo_b = i_quo_b;
        n_quo_a[BIT_IDX] = w_geq_a;
        n_quo_b[BIT_IDX] = w_geq_b;
    end

    // Advance the valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    // Hand the payload to the next cell
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_flags <= i_flags;
            o_side  <= i_side;
            o_den   <= i_den;
            o_rem_a <= n_rem_a;
            o_rem_b <= n_rem_b;
            o_quo_a <= n_quo_a;
            o_quo_b <= n_quo_b;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/segment_intersection_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// segment_intersection_core
// Parametric intersection of two segments with snapping of alpha and beta.
// ---------------------------------------------------------------------------
// Channel     | Direction | Payload
// s_axis      | in        | tdata: a.x a.y b.x b.y c.x c.y d.x d.y
// m_axis      | out       | tdata: hit_x hit_y; tuser: status
// cfg         | in        | snap_tolerance
//
// One segment pair per cycle unless the output stalls; results pass through
// one division cell per quotient bit between the front and back stages.
// Synchronous active-low reset clears valid bits and sets the tolerance to 1.
// A stall at the output freezes the whole pipeline in place.
// ---------------------------------------------------------------------------
`include "segment_intersection_core_defines.svh"

module segment_intersection_core
    import sic_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF,
    localparam int IN_W         = ((8 * COORD_BITS + 7) / 8) * 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_cfg_we,
    input  wire [TOL_BITS-1:0]  i_cfg_wdata,
    input  wire                 i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // first_start_x, first_start_y, first_end_x, first_end_y,
    // second_start_x, second_start_y, second_end_x, second_end_y
    input  wire [IN_W-1:0]      i_s_axis_tdata,
    output logic                o_m_axis_tvalid,
    input  wire                 i_m_axis_tready,
    // hit_x, hit_y
    output logic [47:0]         o_m_axis_tdata,
    // status
    output logic [1:0]          o_m_axis_tuser
);

    localparam int C    = COORD_BITS;
    localparam int F    = FRACTION_BITS;
    localparam int D    = C + 1;
    localparam int P    = 2 * D;
    localparam int M    = 2 * C + 3;
    localparam int Q    = INT_LIMIT_BITS + F;
    localparam int RW   = M + Q;
    localparam int LW   = M + INT_LIMIT_BITS;
    localparam int SW   = 2 * C + 2 * D;
    localparam int MW   = F + INT_LIMIT_BITS + 1;
    localparam int PW   = MW + 1;
    localparam int AW   = F + 2;
    localparam int VW   = AW + D;
    localparam int TW0  = VW + 4;
    localparam int TW   = (TW0 > HIT_BITS + 1) ? TW0 : HIT_BITS + 1;
    localparam int SH   = F - 8;
    localparam int HSH  = (SH > 0) ? SH - 1 : 0;
    localparam logic signed [TW-1:0] HALF = (SH > 0) ? (TW'(1) << HSH) : '0;
    localparam logic signed [PW-1:0] ONE  = PW'(1) << F;
    localparam logic [MW-1:0]        SAT  = MW'(1) << (F + INT_LIMIT_BITS);
    localparam logic signed [TW-1:0] HMAX = (TW'(1) << (HIT_BITS - 1)) - TW'(1);
    localparam logic signed [TW-1:0] HMIN = -(TW'(1) << (HIT_BITS - 1));

    logic                r_tol_wr;
    logic [TOL_BITS-1:0] r_tol;
    logic                w_en;

    // Snap a signed magnitude to 0, then to 1
    function automatic logic signed [PW-1:0] snap(input logic [MW-1:0] mag,
                                                  input logic neg,
                                                  input logic [TOL_BITS-1:0] tol);
        logic signed [PW-1:0] p;
        logic signed [PW-1:0] d;
        logic [PW-1:0]        ad;
        p = neg ? -$signed(PW'(mag)) : $signed(PW'(mag));
        if (PW'(mag) < PW'(tol)) begin
            p = '0;
        end
        d  = p - ONE;
        ad = d[PW-1] ? PW'(-d) : PW'(d);
        if (ad < PW'(tol)) begin
            p = ONE;
        end
        return p;
    endfunction

    // Hold the tolerance register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol    <= TOL_RESET;
            r_tol_wr <= 1'b0;
        end else begin
            r_tol_wr <= i_cfg_we;
            if (i_cfg_we) begin
                r_tol <= i_cfg_wdata;
            end
        end
    end

    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // ---------------- stage 1: differences ----------------
    logic signed [C-1:0] w_ax, w_ay, w_bx, w_by, w_cx, w_cy, w_dx, w_dy;
    logic                r1_v;
    logic signed [C-1:0] r1_ax, r1_ay;
    logic signed [D-1:0] r1_rx, r1_ry, r1_sx, r1_sy, r1_ex, r1_ey;

    assign w_ax = $signed(i_s_axis_tdata[0*C +: C]);
    assign w_ay = $signed(i_s_axis_tdata[1*C +: C]);
    assign w_bx = $signed(i_s_axis_tdata[2*C +: C]);
    assign w_by = $signed(i_s_axis_tdata[3*C +: C]);
    assign w_cx = $signed(i_s_axis_tdata[4*C +: C]);
    assign w_cy = $signed(i_s_axis_tdata[5*C +: C]);
    assign w_dx = $signed(i_s_axis_tdata[6*C +: C]);
    assign w_dy = $signed(i_s_axis_tdata[7*C +: C]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ax <= w_ax;
            r1_ay <= w_ay;
            r1_rx <= D'(w_bx) - D'(w_ax);
            r1_ry <= D'(w_by) - D'(w_ay);
            r1_sx <= D'(w_dx) - D'(w_cx);
            r1_sy <= D'(w_dy) - D'(w_cy);
            r1_ex <= D'(w_cx) - D'(w_ax);
            r1_ey <= D'(w_cy) - D'(w_ay);
        end
    end

    // ---------------- stage 2: cross-product terms ----------------
    logic                r2_v;
    logic signed [C-1:0] r2_ax, r2_ay;
    logic signed [D-1:0] r2_rx, r2_ry;
    logic signed [P-1:0] r2_rysx, r2_syrx, r2_sxey, r2_syex, r2_rxey, r2_ryex;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_rx   <= r1_rx;
            r2_ry   <= r1_ry;
            r2_rysx <= r1_ry * r1_sx;
            r2_syrx <= r1_sy * r1_rx;
            r2_sxey <= r1_sx * r1_ey;
            r2_syex <= r1_sy * r1_ex;
            r2_rxey <= r1_rx * r1_ey;
            r2_ryex <= r1_ry * r1_ex;
        end
    end

    // ---------------- stage 3: denominator and magnitudes ----------------
    logic signed [M-1:0] w_den, w_na, w_nb;
    logic                r3_v;
    logic                r3_zero, r3_neg_a, r3_neg_b;
    logic [M-1:0]        r3_den, r3_mag_a, r3_mag_b;
    logic [SW-1:0]       r3_side;

    always_comb begin
        w_den = M'(r2_rysx) - M'(r2_syrx);
        w_na  = M'(r2_sxey) - M'(r2_syex);
        w_nb  = M'(r2_rxey) - M'(r2_ryex);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_zero  <= (w_den == '0);
            r3_den   <= w_den[M-1] ? M'(-w_den) : M'(w_den);
            r3_mag_a <= w_na[M-1] ? M'(-w_na) : M'(w_na);
            r3_mag_b <= w_nb[M-1] ? M'(-w_nb) : M'(w_nb);
            r3_neg_a <= w_na[M-1] ^ w_den[M-1];
            r3_neg_b <= w_nb[M-1] ^ w_den[M-1];
            r3_side  <= {r2_ry, r2_rx, r2_ay, r2_ax};
        end
    end

    // ---------------- division chain ----------------
    logic [LW-1:0] w_lim;
    t_flags        w_flags0;

    logic          w_cv   [0:Q];
    t_flags        w_cf   [0:Q];
    logic [SW-1:0] w_cs   [0:Q];
    logic [M-1:0]  w_cd   [0:Q];
    logic [RW-1:0] w_cra  [0:Q];
    logic [RW-1:0] w_crb  [0:Q];
    logic [Q-1:0]  w_cqa  [0:Q];
    logic [Q-1:0]  w_cqb  [0:Q];

    // Flag quotients of 2^17 or more
    always_comb begin
        w_lim             = LW'(r3_den) << INT_LIMIT_BITS;
        w_flags0.den_zero = r3_zero;
        w_flags0.neg_a    = r3_neg_a;
        w_flags0.neg_b    = r3_neg_b;
        w_flags0.ovf_a    = (LW'(r3_mag_a) >= w_lim);
        w_flags0.ovf_b    = (LW'(r3_mag_b) >= w_lim);
    end

    assign w_cv[0]  = r3_v;
    assign w_cf[0]  = w_flags0;
    assign w_cs[0]  = r3_side;
    assign w_cd[0]  = r3_den;
    assign w_cra[0] = RW'(r3_mag_a) << F;
    assign w_crb[0] = RW'(r3_mag_b) << F;
    assign w_cqa[0] = '0;
    assign w_cqb[0] = '0;

    for (genvar g = 0; g < Q; g++) begin : g_cell
        sic_div_cell #(
            .DEN_BITS  (M),
            .REM_BITS  (RW),
            .QUO_BITS  (Q),
            .BIT_IDX   (Q - 1 - g),
            .SIDE_BITS (SW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cv[g]),
            .i_flags (w_cf[g]),
            .i_side  (w_cs[g]),
            .i_den   (w_cd[g]),
            .i_rem_a (w_cra[g]),
            .i_rem_b (w_crb[g]),
            .i_quo_a (w_cqa[g]),
            .i_quo_b (w_cqb[g]),
            .o_valid (w_cv[g+1]),
            .o_flags (w_cf[g+1]),
            .o_side  (w_cs[g+1]),
            .o_den   (w_cd[g+1]),
            .o_rem_a (w_cra[g+1]),
            .o_rem_b (w_crb[g+1]),
            .o_quo_a (w_cqa[g+1]),
            .o_quo_b (w_cqb[g+1])
        );
    end

    // ---------------- stage 5: sign and snap ----------------
    logic [MW-1:0]        w_mag_a, w_mag_b;
    logic                 r5_v, r5_zero;
    logic signed [PW-1:0] r5_alpha, r5_beta;
    logic [SW-1:0]        r5_side;

    always_comb begin
        w_mag_a = w_cf[Q].ovf_a ? SAT : MW'(w_cqa[Q]);
        w_mag_b = w_cf[Q].ovf_b ? SAT : MW'(w_cqb[Q]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= w_cv[Q];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_zero  <= w_cf[Q].den_zero;
            r5_alpha <= snap(w_mag_a, w_cf[Q].neg_a, r_tol);
            r5_beta  <= snap(w_mag_b, w_cf[Q].neg_b, r_tol);
            r5_side  <= w_cs[Q];
        end
    end

    // ---------------- stage 6: status and scaling ----------------
    logic signed [C-1:0]  w_ax5, w_ay5;
    logic signed [D-1:0]  w_rx5, w_ry5;
    logic signed [AW-1:0] w_alpha_c;
    logic                 w_out_a, w_out_b;
    logic [1:0]           w_status;
    logic                 r6_v;
    logic [1:0]           r6_status;
    logic signed [VW-1:0] r6_vx, r6_vy;
    logic signed [C-1:0]  r6_ax, r6_ay;

    always_comb begin
        w_ax5     = $signed(r5_side[0 +: C]);
        w_ay5     = $signed(r5_side[C +: C]);
        w_rx5     = $signed(r5_side[2*C +: D]);
        w_ry5     = $signed(r5_side[2*C+D +: D]);
        w_alpha_c = $signed(r5_alpha[AW-1:0]);
        w_out_a   = r5_alpha[PW-1] || (r5_alpha > ONE);
        w_out_b   = r5_beta[PW-1] || (r5_beta > ONE);
        if (r5_zero || w_out_a) begin
            w_status = ST_FIRST;
        end else if (w_out_b) begin
            w_status = ST_SECOND;
        end else begin
            w_status = ST_FOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (w_en) begin
            r6_v <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_status <= w_status;
            r6_vx     <= w_alpha_c * w_rx5;
            r6_vy     <= w_alpha_c * w_ry5;
            r6_ax     <= w_ax5;
            r6_ay     <= w_ay5;
        end
    end

    // ---------------- stage 7: round, offset, saturate ----------------
    logic signed [TW-1:0] w_tx, w_ty;
    logic [HIT_BITS-1:0]  w_hx, w_hy;
    logic                 r7_v;
    logic [1:0]           r7_status;
    logic [HIT_BITS-1:0]  r7_hx, r7_hy;

    always_comb begin
        w_tx = ((TW'(r6_vx) + HALF) >>> SH) + (TW'(r6_ax) <<< 8);
        w_ty = ((TW'(r6_vy) + HALF) >>> SH) + (TW'(r6_ay) <<< 8);
        if (w_tx > HMAX) begin
            w_hx = HMAX[HIT_BITS-1:0];
        end else if (w_tx < HMIN) begin
            w_hx = HMIN[HIT_BITS-1:0];
        end else begin
            w_hx = w_tx[HIT_BITS-1:0];
        end
        if (w_ty > HMAX) begin
            w_hy = HMAX[HIT_BITS-1:0];
        end else if (w_ty < HMIN) begin
            w_hy = HMIN[HIT_BITS-1:0];
        end else begin
            w_hy = w_ty[HIT_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (w_en) begin
            r7_v <= r6_v;
        end
    end

    // Drop the point unless it was found
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_status <= r6_status;
            r7_hx     <= (r6_status == ST_FOUND) ? w_hx : '0;
            r7_hy     <= (r6_status == ST_FOUND) ? w_hy : '0;
        end
    end

    assign o_m_axis_tvalid = r7_v;
    assign o_m_axis_tuser  = r7_status;
    assign o_m_axis_tdata  = {r7_hy, r7_hx};

    // ---------------- assertions ----------------
    `SIC_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n,
        o_m_axis_tvalid && (o_m_axis_tuser != ST_FOUND), o_m_axis_tdata == '0,
        "point not cleared on a miss")
    `SIC_ASSERT_IMP(a_status_legal, i_clk, i_rst_n, o_m_axis_tvalid,
        (o_m_axis_tuser == ST_FOUND) || (o_m_axis_tuser == ST_FIRST) ||
        (o_m_axis_tuser == ST_SECOND), "illegal status code")
    `SIC_ASSERT_NXT(a_tol_write, i_clk, i_rst_n, i_cfg_we,
        r_tol_wr && (r_tol == $past(i_cfg_wdata)), "tolerance write lost")

endmodule
`default_nettype wire

// ===== dv/tb_segment_intersection_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Segment intersection core testbench
// Streams segment pairs through the core under several snap tolerances and
// idling patterns, predicts status and hit point per pair and compares each
// output transfer in order against the predicted results.
// ---------------------------------------------------------------------------
module tb_segment_intersection_core;
    import sic_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] hit_x;
        logic [23:0] hit_y;
    } t_hit;

    localparam int N_PHASES = 5;
    localparam int N_RANDOM = 250;
    localparam int SETTLE   = 60;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_we;
    logic [15:0]  i_cfg_wdata;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [47:0]  o_m_axis_tdata;
    logic [1:0]   o_m_axis_tuser;

    logic [127:0] pair_queue[$];
    t_hit         hit_queue[$];
    longint       tolerance;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           errors;
    int           checked;
    int           found_count;
    int           second_count;

    segment_intersection_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Signed magnitude quotient with truncation and saturation
    function automatic longint param_quotient(longint n, longint d);
        longint unsigned m;
        longint unsigned r;
        longint unsigned mag;
        m = (n < 0) ? longint'(-n) : longint'(n);
        mag = m / longint'(d);
        r = m % longint'(d);
        if (mag >= (64'd1 << INT_LIMIT_BITS)) begin
            mag = 64'd1 << (FRACTION_BITS_DEF + INT_LIMIT_BITS);
        end else begin
            for (int i = 0; i < FRACTION_BITS_DEF; i++) begin
                r = r << 1;
                mag = mag << 1;
                if (r >= longint'(d)) begin
                    r = r - longint'(d);
                    mag = mag | 64'd1;
                end
            end
        end
        return (n < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    // Snap to zero first, then to one, both strict
    function automatic longint snap_param(longint p);
        longint one;
        one = 64'sd1 << FRACTION_BITS_DEF;
        if ((p < 0 ? -p : p) < tolerance) p = 0;
        if (((p - one) < 0 ? one - p : p - one) < tolerance) p = one;
        return p;
    endfunction

    function automatic logic [23:0] hit_coord(longint s, longint dlt, longint p);
        longint v;
        longint t;
        longint lim;
        v = p * dlt + 128;
        lim = 64'sd1 << (HIT_BITS - 1);
        if (v >= 0) t = v >>> 8;
        else t = -((-v + 255) >>> 8);
        t = t + s * 256;
        if (t > lim - 1) t = lim - 1;
        if (t < -lim) t = -lim;
        return t[23:0];
    endfunction

    function automatic t_hit predict_hit(logic [127:0] d);
        longint ax, ay, bx, by, cx, cy, dx, dy;
        longint rx, ry, sx, sy, den, na, nb, alpha, beta;
        t_hit h;
        ax = longint'($signed(d[0+:16]));   ay = longint'($signed(d[16+:16]));
        bx = longint'($signed(d[32+:16]));  by = longint'($signed(d[48+:16]));
        cx = longint'($signed(d[64+:16]));  cy = longint'($signed(d[80+:16]));
        dx = longint'($signed(d[96+:16]));  dy = longint'($signed(d[112+:16]));
        rx = bx - ax; ry = by - ay;
        sx = dx - cx; sy = dy - cy;
        den = ry * sx - sy * rx;
        na = sx * (cy - ay) - sy * (cx - ax);
        nb = ry * (ax - cx) - rx * (ay - cy);
        h = '{status: ST_FIRST, hit_x: '0, hit_y: '0};
        if (den == 0) return h;
        if (den < 0) begin
            den = -den; na = -na; nb = -nb;
        end
        alpha = snap_param(param_quotient(na, den));
        if (alpha < 0 || alpha > (64'sd1 << FRACTION_BITS_DEF)) return h;
        beta = snap_param(param_quotient(nb, den));
        if (beta < 0 || beta > (64'sd1 << FRACTION_BITS_DEF)) begin
            h.status = ST_SECOND;
            return h;
        end
        h.status = ST_FOUND;
        h.hit_x = hit_coord(ax, rx, alpha);
        h.hit_y = hit_coord(ay, ry, alpha);
        return h;
    endfunction

    function automatic logic [127:0] pack_pair(int ax, int ay, int bx, int by,
                                               int cx, int cy, int dx, int dy);
        return {dy[15:0], dx[15:0], cy[15:0], cx[15:0],
                by[15:0], bx[15:0], ay[15:0], ax[15:0]};
    endfunction

    function automatic int rand_coord(int span);
        return $urandom_range(2 * span) - span;
    endfunction

    // Driver: present pending pairs, predict on each accepted transfer
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                hit_queue.push_back(predict_hit(i_s_axis_tdata));
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pair_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= pair_queue.pop_front();
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                    i_s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom};
                end
            end
        end
    end

    // Monitor: compare each output transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_hit want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (hit_queue.size() == 0) begin
                    $display("%0t: unexpected result status=%0d data=%h", $realtime,
                             o_m_axis_tuser, o_m_axis_tdata);
                    errors++;
                end else begin
                    want = hit_queue.pop_front();
                    checked++;
                    if (want.status == ST_FOUND) found_count++;
                    if (want.status == ST_SECOND) second_count++;
                    if (o_m_axis_tuser !== want.status) begin
                        $display("%0t: status expected %0d actual %0d", $realtime,
                                 want.status, o_m_axis_tuser);
                        errors++;
                    end
                    if (o_m_axis_tdata[23:0] !== want.hit_x) begin
                        $display("%0t: hit_x expected %h actual %h", $realtime,
                                 want.hit_x, o_m_axis_tdata[23:0]);
                        errors++;
                    end
                    if (o_m_axis_tdata[47:24] !== want.hit_y) begin
                        $display("%0t: hit_y expected %h actual %h", $realtime,
                                 want.hit_y, o_m_axis_tdata[47:24]);
                        errors++;
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic write_tolerance(logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        tolerance = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic load_directed();
        // field extremes
        pair_queue.push_back(pack_pair(-32768, -32768, -32768, -32768,
                                       -32768, -32768, -32768, -32768));
        pair_queue.push_back(pack_pair(32767, 32767, 32767, 32767,
                                       32767, 32767, 32767, 32767));
        pair_queue.push_back(pack_pair(-32768, -32768, 32767, 32767,
                                       -32768, 32767, 32767, -32768));
        pair_queue.push_back(pack_pair(32767, -32768, -32768, 32767,
                                       -32768, -32768, 32767, 32767));
        // plain crossing, rounded hit point
        pair_queue.push_back(pack_pair(0, 0, 10, 10, 0, 10, 10, 0));
        pair_queue.push_back(pack_pair(0, 0, 3, 7, 0, 5, 7, -1));
        pair_queue.push_back(pack_pair(-5, -3, 2, 9, -7, 4, 6, -2));
        // parallel and collinear
        pair_queue.push_back(pack_pair(0, 0, 10, 0, 0, 5, 10, 5));
        pair_queue.push_back(pack_pair(0, 0, 10, 0, 2, 0, 8, 0));
        // shared end points: alpha exactly 0 or 1
        pair_queue.push_back(pack_pair(0, 0, 10, 0, 0, 0, 0, 10));
        pair_queue.push_back(pack_pair(0, 0, 10, 0, 10, -5, 10, 5));
        // just outside the first and the second segment
        pair_queue.push_back(pack_pair(0, 0, 30000, 0, 30001, -5, 30001, 5));
        pair_queue.push_back(pack_pair(0, 0, 30000, 1, 15000, 2, 15000, 30000));
        pair_queue.push_back(pack_pair(0, -1, 0, 1, 30000, 0, 1, 0));
        // far outside the first segment: large alpha
        pair_queue.push_back(pack_pair(0, 0, 1, 0, 30000, -32768, 30001, 32767));
        // negative denominator
        pair_queue.push_back(pack_pair(0, 10, 10, 0, 0, 0, 10, 10));
    endtask

    task automatic load_random(int count);
        int ax, ay, bx, by, cx, cy, dx, dy, span;
        for (int i = 0; i < count; i++) begin
            span = ($urandom_range(3) == 0) ? 32767 : ($urandom_range(1) ? 200 : 20);
            ax = rand_coord(span); ay = rand_coord(span);
            bx = rand_coord(span); by = rand_coord(span);
            cx = rand_coord(span); cy = rand_coord(span);
            dx = rand_coord(span); dy = rand_coord(span);
            case ($urandom_range(9))
                0: begin
                    // full range, every bit toggles
                    pair_queue.push_back({$urandom, $urandom, $urandom, $urandom});
                    continue;
                end
                1: begin
                    // second segment starts on an end of the first
                    cx = ax; cy = ay;
                end
                2: begin
                    cx = bx; cy = by;
                end
                3: begin
                    // end of second lies close to the first line near b
                    dx = bx + $urandom_range(2) - 1; dy = by + $urandom_range(2) - 1;
                end
                4: begin
                    // parallel to the first segment
                    dx = cx + (bx - ax); dy = cy + (by - ay);
                end
                default: begin
                    // straddle: d mirrors c about the first segment midpoint
                    dx = ax + bx - cx; dy = ay + by - cy;
                end
            endcase
            if (dx > 32767) dx = 32767;
            if (dx < -32768) dx = -32768;
            if (dy > 32767) dy = 32767;
            if (dy < -32768) dy = -32768;
            pair_queue.push_back(pack_pair(ax, ay, bx, by, cx, cy, dx, dy));
        end
    endtask

    task automatic drain();
        while (pair_queue.size() > 0 || hit_queue.size() > 0 || i_s_axis_tvalid)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Stimulus: phases of tolerance and idling
    initial begin
        logic [15:0] tol_set[N_PHASES];
        tol_set = '{16'd1, 16'd0, 16'hFFFF, 16'd1000, 16'd0};
        tol_set[3] = $urandom_range(65535);
        errors = 0; checked = 0; found_count = 0; second_count = 0;
        tolerance = TOL_RESET;
        send_idle_pct = 0; recv_stall_pct = 0;
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_wdata = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph > 0) write_tolerance(tol_set[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            if (ph == 0 || ph == 2) load_directed();
            load_random(N_RANDOM);
            drain();
        end
        $display("Checked %0d results over %0d tolerance settings and four idling patterns",
                 checked, N_PHASES);
        $display("Results found %0d, off second segment %0d, remaining off first or parallel",
                 found_count, second_count);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
